// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that stays active during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/brle_pkg.sv =====
// Shared types and constants of the byte run-length encoder.
// Depends on nothing; every module imports it.
`default_nettype none

package brle_pkg;

	localparam int MAX_RUN    = 257;
	localparam int RUN_W      = 9;
	localparam int CMD_DEPTH  = 4;
	localparam int CMD_AW     = 2;
	localparam int CMD_CNT_W  = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       batch_end;
		logic       stream_end;
	} out_item_t;

	// One finished run, ready to be expanded into one or three bytes.
	typedef struct packed {
		logic [7:0] value;
		logic       single;
		logic [7:0] count;
		logic       batch_end;
		logic       stream_end;
	} run_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/brle_front.sv =====
// Front end: accepts raw bytes, tracks the open run and emits run commands.
// Depends on brle_pkg.
`default_nettype none

module brle_front
	import brle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	input  wire logic     cmd_full,
	output logic          cmd_push,
	output run_cmd_t      cmd
);

	logic [7:0]       pending_q;
	logic [RUN_W-1:0] run_len_q;
	logic             hold_valid_q;
	run_cmd_t         hold_q;

	logic             accept;
	logic             run_open;
	logic             extend;
	logic             brk;
	logic [RUN_W-1:0] next_len;
	run_cmd_t         brk_cmd;
	run_cmd_t         flush_cmd;

	function automatic run_cmd_t make_cmd(input logic [7:0] value, input logic [RUN_W-1:0] len,
		input logic batch_end, input logic stream_end);
		run_cmd_t         c;
		logic [RUN_W-1:0] diff;
		diff         = len - RUN_W'(2);
		c.value      = value;
		c.single     = (len == RUN_W'(1));
		c.count      = diff[7:0];
		c.batch_end  = batch_end;
		c.stream_end = stream_end;
		return c;
	endfunction

	always_comb begin
		full     = hold_valid_q || cmd_full;
		accept   = push && !full;
		run_open = (run_len_q != '0);
		extend   = (item.data_byte == pending_q) && (run_len_q < RUN_W'(MAX_RUN));
		brk      = run_open && !extend;
		next_len = (run_open && extend) ? run_len_q + RUN_W'(1) : RUN_W'(1);

		brk_cmd   = make_cmd(pending_q, run_len_q, !item.final_byte, 1'b0);
		flush_cmd = make_cmd(item.data_byte, next_len, 1'b1, 1'b1);

		// A final byte that also breaks a run yields two commands; the
		// second one waits in the hold register until the queue has room.
		cmd_push = (accept && (brk || item.final_byte)) || (hold_valid_q && !cmd_full);
		if (hold_valid_q) begin
			cmd = hold_q;
		end else if (brk) begin
			cmd = brk_cmd;
		end else begin
			cmd = flush_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			run_len_q    <= '0;
			hold_valid_q <= 1'b0;
			hold_q       <= '0;
		end else begin
			if (hold_valid_q && !cmd_full) begin
				hold_valid_q <= 1'b0;
			end
			if (accept) begin
				if (item.final_byte) begin
					pending_q <= '0;
					run_len_q <= '0;
				end else begin
					pending_q <= item.data_byte;
					run_len_q <= next_len;
				end
				hold_valid_q <= brk && item.final_byte;
				hold_q       <= flush_cmd;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/brle_cmd_fifo.sv =====
// Short command queue between the front end and the byte expander.
// Depends on brle_pkg.
`default_nettype none

module brle_cmd_fifo
	import brle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire run_cmd_t wdata,
	output logic          full,
	input  wire logic     pop,
	output run_cmd_t      rdata,
	output logic          empty
);

	run_cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0]     wr_ptr_q;
	logic [CMD_AW-1:0]     rd_ptr_q;
	logic [CMD_CNT_W-1:0]  cnt_q;
	logic                  do_push;
	logic                  do_pop;

	always_comb begin
		full    = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
		empty   = (cnt_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/brle_back.sv =====
// Back end: expands run commands into encoded bytes in the output register,
// one byte per cycle while that register is free or popped. Depends on brle_pkg.
`default_nettype none

module brle_back
	import brle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_empty,
	input  wire run_cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_COUNT
	} phase_t;

	phase_t    phase_q;
	logic      out_valid_q;
	out_item_t result_q;
	logic      advance;
	logic      take;

	always_comb begin
		empty   = !out_valid_q;
		result  = result_q;
		advance = !out_valid_q || pop;
		take    = advance && !cmd_empty;
		cmd_pop = 1'b0;
		if (take) begin
			case (phase_q)
				PH_FIRST:  cmd_pop = cmd.single;
				PH_SECOND: cmd_pop = 1'b0;
				PH_COUNT:  cmd_pop = 1'b1;
				default:   cmd_pop = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else if (advance) begin
			out_valid_q <= !cmd_empty;
			if (take) begin
				case (phase_q)
					PH_FIRST: begin
						result_q.code_byte <= cmd.value;
						if (cmd.single) begin
							result_q.batch_end  <= cmd.batch_end;
							result_q.stream_end <= cmd.stream_end;
						end else begin
							result_q.batch_end  <= 1'b0;
							result_q.stream_end <= 1'b0;
							phase_q             <= PH_SECOND;
						end
					end
					PH_SECOND: begin
						result_q.code_byte  <= cmd.value;
						result_q.batch_end  <= 1'b0;
						result_q.stream_end <= 1'b0;
						phase_q             <= PH_COUNT;
					end
					PH_COUNT: begin
						result_q.code_byte  <= cmd.count;
						result_q.batch_end  <= cmd.batch_end;
						result_q.stream_end <= cmd.stream_end;
						phase_q             <= PH_FIRST;
					end
					default: begin
						phase_q <= PH_FIRST;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/byte_run_length_encoder_top.sv =====
// Byte run-length encoder. Raw bytes are taken by request on the push/full
// side; a run of one byte comes out as that byte, a longer run (up to 257)
// as the byte twice and then a count byte of length minus two. The front end
// takes one byte per cycle whenever the four-entry run command queue has
// room; a final byte that also closes an earlier run holds it off until its
// second command leaves the hold register. The back end sends one encoded
// byte per cycle while results are taken, so a closed run occupies it for
// one or three bytes; that rate sets the sustained throughput, worst for
// streams of runs of two. With the queue and the back end idle, the first
// byte of a closed run is stored in the command queue and then in the output
// register. Depends on brle_pkg and the brle_* submodules.
`default_nettype none

module byte_run_length_encoder_top
	import brle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic     cmd_push;
	logic     cmd_full;
	logic     cmd_pop;
	logic     cmd_empty;
	run_cmd_t cmd_wr;
	run_cmd_t cmd_rd;

	brle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr)
	);

	brle_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wr),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rd),
		.empty  (cmd_empty)
	);

	brle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== rtl/brle_checker.sv =====
// Port-level checks for the byte run-length encoder, bound to the top level.
// Depends on brle_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module brle_checker
	import brle_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_item_t result
);

	// A waiting result must not change until it is taken.
	`ASSERT_CLK(a_result_held, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while stalled")

	// The last byte of a stream is always the last byte of its request.
	`ASSERT_CLK(a_stream_end_batch, clk, arst_n, (!empty && result.stream_end) |-> result.batch_end, "stream_end without batch_end")

	// Nothing can be waiting on the result side right after reset.
	`ASSERT_CLK_ALWAYS(a_empty_after_reset, clk, $past(!arst_n) |-> empty, "result shown right after reset")

	// A request never reaches the result side combinationally, only after it is accepted.
	`ASSERT_CLK(a_no_bypass, clk, arst_n, (empty && !$past(push && !full)) |=> empty, "result shown too early")

endmodule

bind byte_run_length_encoder_top brle_checker u_brle_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

// ===== tb/byte_run_length_encoder_top_tb.sv =====
// Self-checking testbench for byte_run_length_encoder_top: a directed table, a run
// past the maximum length, then random streams; a run-length predictor scores
// all but typed rows. Depends on brle_pkg and the encoder RTL; reads and writes no files.
`default_nettype none

module byte_run_length_encoder_top_tb;
	import brle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PREDICT        = -1;
	localparam int RANDOM_ITEMS   = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int IDLE_PCT       = 24;
	localparam int MAX_PRINTED    = 40;

	typedef struct {
		in_item_t  req;
		int        n_typed;
		out_item_t res [4];
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	// Predictor state: the byte of the open run and its length, zero when no run is open.
	logic [7:0] pend_val;
	logic [8:0] run_len;

	out_item_t code_q [$];
	dir_row_t  dir_tab [$];
	int        mismatches;
	int        sent_rand;
	bit        calm;

	byte_run_length_encoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic out_item_t mk_out(input logic [7:0] c, input bit be, input bit se);
		out_item_t o;
		o.code_byte  = c;
		o.batch_end  = be;
		o.stream_end = se;
		return o;
	endfunction

	function automatic dir_row_t mk_row(input logic [7:0] d, input bit f, input int n,
			input out_item_t r0 = '0, input out_item_t r1 = '0,
			input out_item_t r2 = '0, input out_item_t r3 = '0);
		dir_row_t r;
		r.req.data_byte  = d;
		r.req.final_byte = f;
		r.n_typed        = n;
		r.res[0]         = r0;
		r.res[1]         = r1;
		r.res[2]         = r2;
		r.res[3]         = r3;
		return r;
	endfunction

	function automatic void flush_run(ref out_item_t burst [$]);
		if (run_len == 9'd0)
			return;
		burst.push_back(mk_out(pend_val, 1'b0, 1'b0));
		if (run_len > 9'd1) begin
			burst.push_back(mk_out(pend_val, 1'b0, 1'b0));
			burst.push_back(mk_out(8'(run_len - 9'd2), 1'b0, 1'b0));
		end
	endfunction

	// Works out the encoded bytes that one raw byte releases and advances the run state.
	function automatic void encode_byte(input in_item_t req, ref out_item_t burst [$]);
		burst.delete();
		if (run_len == 9'd0) begin
			pend_val = req.data_byte;
			run_len  = 9'd1;
		end else if (req.data_byte == pend_val && run_len < MAX_RUN) begin
			run_len = run_len + 9'd1;
		end else begin
			flush_run(burst);
			pend_val = req.data_byte;
			run_len  = 9'd1;
		end
		if (req.final_byte) begin
			flush_run(burst);
			pend_val = 8'd0;
			run_len  = 9'd0;
		end
		if (burst.size() > 0) begin
			burst[burst.size() - 1].batch_end  = 1'b1;
			burst[burst.size() - 1].stream_end = req.final_byte;
		end
	endfunction

	task automatic send_req(input in_item_t req, ref out_item_t burst [$]);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full)
			@(posedge clk);
		encode_byte(req, burst);
	endtask

	task automatic send_byte(input logic [7:0] d, input bit f);
		in_item_t  req;
		out_item_t burst [$];
		req.data_byte  = d;
		req.final_byte = f;
		send_req(req, burst);
		foreach (burst[i])
			code_q.push_back(burst[i]);
		sent_rand++;
	endtask

	// Mostly well-formed streams of runs over a small or a full alphabet, some
	// streams of raw noise whose final flags fall at random.
	task automatic send_stream();
		int unsigned len;
		int unsigned k;
		int unsigned run;
		int unsigned pick;
		logic [7:0]  val;
		bit          noise;
		len   = $urandom_range(1, 16);
		noise = ($urandom_range(99) < 15);
		k     = 0;
		while (k < len) begin
			if (noise) begin
				send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
				k++;
			end else begin
				val  = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
				pick = $urandom_range(99);
				if (pick < 55)
					run = 1;
				else if (pick < 94)
					run = $urandom_range(2, 6);
				else
					run = $urandom_range(7, 30);
				for (int j = 0; j < run && k < len; j++) begin
					send_byte(val, k + 1 == len);
					k++;
				end
			end
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (code_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result code_byte=%02h", got.code_byte));
			return;
		end
		want = code_q.pop_front();
		if (got.code_byte !== want.code_byte)
			report_mismatch($sformatf("code_byte %02h, want %02h", got.code_byte,
				want.code_byte));
		if (got.batch_end !== want.batch_end)
			report_mismatch($sformatf("batch_end %b, want %b (code_byte %02h)", got.batch_end,
				want.batch_end, want.code_byte));
		if (got.stream_end !== want.stream_end)
			report_mismatch($sformatf("stream_end %b, want %b (code_byte %02h)",
				got.stream_end, want.stream_end, want.code_byte));
	endtask

	// Result side: pop is redrawn every cycle, checked against the oldest expectation.
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_result(result);
			pop <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		out_item_t   burst [$];
		int unsigned long_len;
		logic [7:0]  long_val;

		arst_n     <= 1'b0;
		push       <= 1'b0;
		item       <= '0;
		mismatches = 0;
		sent_rand  = 0;
		calm       = 1'b0;
		pend_val   = 8'd0;
		run_len    = 9'd0;

		// Single-byte streams at both extremes, then runs of two and mixed runs.
		dir_tab.push_back(mk_row(8'h00, 1'b1, 1, mk_out(8'h00, 1'b1, 1'b1)));
		dir_tab.push_back(mk_row(8'hFF, 1'b1, 1, mk_out(8'hFF, 1'b1, 1'b1)));
		dir_tab.push_back(mk_row(8'hA5, 1'b0, 0));
		dir_tab.push_back(mk_row(8'hA5, 1'b1, 3, mk_out(8'hA5, 1'b0, 1'b0),
			mk_out(8'hA5, 1'b0, 1'b0), mk_out(8'h00, 1'b1, 1'b1)));
		dir_tab.push_back(mk_row(8'h12, 1'b0, 0));
		dir_tab.push_back(mk_row(8'h34, 1'b0, 1, mk_out(8'h12, 1'b1, 1'b0)));
		dir_tab.push_back(mk_row(8'h34, 1'b0, PREDICT));
		dir_tab.push_back(mk_row(8'h56, 1'b1, 4, mk_out(8'h34, 1'b0, 1'b0),
			mk_out(8'h34, 1'b0, 1'b0), mk_out(8'h00, 1'b0, 1'b0),
			mk_out(8'h56, 1'b1, 1'b1)));
		repeat (3)
			dir_tab.push_back(mk_row(8'h80, 1'b0, PREDICT));
		dir_tab.push_back(mk_row(8'h80, 1'b1, PREDICT));
		for (int b = 0; b < 8; b++)
			dir_tab.push_back(mk_row(8'(1 << b), b == 7, PREDICT));
		dir_tab.push_back(mk_row(8'h7F, 1'b0, PREDICT));
		dir_tab.push_back(mk_row(8'h7F, 1'b0, PREDICT));
		dir_tab.push_back(mk_row(8'hFE, 1'b0, PREDICT));
		dir_tab.push_back(mk_row(8'hFE, 1'b1, PREDICT));

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_req(dir_tab[i].req, burst);
			if (dir_tab[i].n_typed == PREDICT) begin
				foreach (burst[k])
					code_q.push_back(burst[k]);
			end else begin
				for (int k = 0; k < dir_tab[i].n_typed; k++)
					code_q.push_back(dir_tab[i].res[k]);
			end
		end

		// A run longer than the limit: the full run is closed with count byte FF and the
		// next equal byte opens a new run.
		long_len = $urandom_range(MAX_RUN + 1, MAX_RUN + 3);
		long_val = 8'($urandom_range(255));
		for (int unsigned n = 1; n <= long_len; n++)
			send_byte(long_val, n == long_len);

		sent_rand = 0;
		while (sent_rand < RANDOM_ITEMS) begin
			calm = (sent_rand >= 20 && sent_rand < 60);
			send_stream();
		end
		// Close any stream that noise left open.
		send_byte(8'($urandom_range(255)), 1'b1);
		push <= 1'b0;
		calm = 1'b0;

		while (code_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/brle_pkg.sv
rtl/brle_front.sv
rtl/brle_cmd_fifo.sv
rtl/brle_back.sv
rtl/byte_run_length_encoder_top.sv
rtl/brle_checker.sv
tb/byte_run_length_encoder_top_tb.sv
